@@ rtl/tthq_pkg.sv @@
// Shared constants and types for the terrain triangle height query block.
// No dependencies; used by the top level and the testbench.
package tthq_pkg;

  localparam int MAX_CELLS_DEFAULT = 64;
  localparam int HEIGHT_BITS       = 24;
  localparam int FRAC_BITS         = 16;
  localparam int OUT_FIFO_DEPTH    = 8;

  localparam logic [6:0]  CELLS_ACROSS_RESET = 7'd64;
  localparam logic [6:0]  CELLS_DOWN_RESET   = 7'd64;
  localparam logic [31:0] INV_CELL_RESET     = 32'd335544;

  typedef enum logic [1:0] {
    CFG_CELLS_ACROSS = 2'd0,
    CFG_CELLS_DOWN   = 2'd1,
    CFG_INV_CELL     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

endpackage

@@ rtl/terrain_triangle_height_query.sv @@
// Top level: vertex height store and triangle interpolation pipeline.
// Depends on tthq_pkg, tthq_ram, tthq_out_fifo.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  config   | cfg_we               | cfg_index, cfg_data
//  input    | in_valid / in_ready  | action, vertex_index, vertex_height, world_x/z
//  output   | out_valid / out_ready| height_out
//
// One item per cycle while in_ready is high. A query passes through the scale
// product, floor and centre, store read, triangle pick and products stages;
// the sum and saturation feed the result buffer, which drives out_valid.
// Heights sit in four copies of the store so all four corners read in the same
// cycle; loads write all copies at the read stage, keeping item order.
// Results queue in an 8-entry buffer; in_ready drops only when 8 queries
// are in flight or waiting. Reset clears control only, no store sweep.
module terrain_triangle_height_query #(
  parameter int MAX_CELLS = tthq_pkg::MAX_CELLS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [12:0]        vertex_index,
  input  logic signed [23:0] vertex_height,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] height_out
);

  localparam int DEPTH = (MAX_CELLS + 1) * (MAX_CELLS + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_CELLS + 2);
  localparam int HB    = tthq_pkg::HEIGHT_BITS;
  localparam int FB    = tthq_pkg::FRAC_BITS;
  localparam int FD    = tthq_pkg::OUT_FIFO_DEPTH;
  localparam int NW    = $clog2(FD + 1);

  // configuration
  logic [6:0]  cells_across;
  logic [6:0]  cells_down;
  logic [31:0] inverse_cell_size;
  logic [CW-1:0] ncols;
  logic [CW-1:0] nrows;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_across      <= tthq_pkg::CELLS_ACROSS_RESET;
      cells_down        <= tthq_pkg::CELLS_DOWN_RESET;
      inverse_cell_size <= tthq_pkg::INV_CELL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tthq_pkg::CFG_CELLS_ACROSS: cells_across      <= cfg_data[6:0];
        tthq_pkg::CFG_CELLS_DOWN:   cells_down        <= cfg_data[6:0];
        tthq_pkg::CFG_INV_CELL:     inverse_cell_size <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ncols = (32'(cells_across) > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cells_across);
  assign nrows = (32'(cells_down) > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cells_down);

  // credits for queries in flight or queued
  logic          accept;
  logic          query_in;
  logic          out_take;
  logic [NW-1:0] credits;
  logic [NW-1:0] credits_next;

  assign accept       = in_valid & in_ready;
  assign query_in     = (action == tthq_pkg::ACT_QUERY);
  assign out_take     = out_valid & out_ready;
  assign in_ready     = (credits < NW'(FD));
  assign credits_next = credits + NW'(accept & query_in) - NW'(out_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

  // stage 1: scale products
  logic [31:0] xmag;
  logic [31:0] zmag;
  logic        znegv;
  logic [63:0] px_c;
  logic [63:0] pz_c;

  assign xmag  = world_x[31] ? 32'(-world_x) : 32'(world_x);
  assign zmag  = world_z[31] ? 32'(-world_z) : 32'(world_z);
  assign znegv = !world_z[31] && (world_z != 32'sd0);  // -z is negative
  assign px_c  = xmag * inverse_cell_size;
  assign pz_c  = zmag * inverse_cell_size;

  logic               s1_valid;
  logic               s1_query;
  logic [12:0]        s1_idx;
  logic signed [23:0] s1_height;
  logic [63:0]        s1_px;
  logic [63:0]        s1_pz;
  logic               s1_negx;
  logic               s1_negz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_query  <= query_in;
    s1_idx    <= vertex_index;
    s1_height <= vertex_height;
    s1_px     <= px_c;
    s1_pz     <= pz_c;
    s1_negx   <= world_x[31];
    s1_negz   <= znegv;
  end

  // stage 2: floor to Q.16 and centre the grid
  logic [63:0]        mx;
  logic [63:0]        mz;
  logic signed [49:0] sx;
  logic signed [49:0] sz;
  logic signed [49:0] u_c;
  logic signed [49:0] w_c;

  assign mx  = s1_negx ? ((s1_px + 64'hFFFF) >> FB) : (s1_px >> FB);
  assign mz  = s1_negz ? ((s1_pz + 64'hFFFF) >> FB) : (s1_pz >> FB);
  assign sx  = s1_negx ? -$signed(50'(mx)) : $signed(50'(mx));
  assign sz  = s1_negz ? -$signed(50'(mz)) : $signed(50'(mz));
  assign u_c = sx + $signed(50'(ncols) << (FB - 1));
  assign w_c = sz + $signed(50'(nrows) << (FB - 1));

  logic               s2_valid;
  logic               s2_query;
  logic [12:0]        s2_idx;
  logic signed [23:0] s2_height;
  logic signed [49:0] s2_u;
  logic signed [49:0] s2_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_query  <= s1_query;
    s2_idx    <= s1_idx;
    s2_height <= s1_height;
    s2_u      <= u_c;
    s2_w      <= w_c;
  end

  // store access: loads write here, queries read all four corners here
  logic signed [33:0] row;
  logic signed [33:0] col;
  logic signed [33:0] nr_s;
  logic signed [33:0] nc_s;
  logic               row0_ok;
  logic               row1_ok;
  logic               col0_ok;
  logic               col1_ok;
  logic [3:0]         in_grid;
  logic [CW-1:0]      r0;
  logic [CW-1:0]      r1;
  logic [CW-1:0]      c0;
  logic [CW-1:0]      c1;
  logic [AW-1:0]      stride;
  logic [AW-1:0]      base0;
  logic [AW-1:0]      base1;
  logic [AW-1:0]      raddr [4];
  logic [AW-1:0]      waddr;
  logic               we;
  logic [HB-1:0]      rdata [4];

  assign row  = s2_w[49:FB];
  assign col  = s2_u[49:FB];
  assign nr_s = $signed(34'(nrows));
  assign nc_s = $signed(34'(ncols));

  assign row0_ok = (row >= 34'sd0)  && (row <= nr_s);
  assign row1_ok = (row >= -34'sd1) && (row < nr_s);
  assign col0_ok = (col >= 34'sd0)  && (col <= nc_s);
  assign col1_ok = (col >= -34'sd1) && (col < nc_s);
  // corners: A (r,c), B (r,c+1), C (r+1,c), D (r+1,c+1)
  assign in_grid = {row1_ok & col1_ok, row1_ok & col0_ok, row0_ok & col1_ok, row0_ok & col0_ok};

  assign r0     = row[CW-1:0];
  assign r1     = r0 + 1'b1;
  assign c0     = col[CW-1:0];
  assign c1     = c0 + 1'b1;
  assign stride = AW'(ncols) + 1'b1;
  assign base0  = AW'(AW'(r0) * stride);
  assign base1  = AW'(AW'(r1) * stride);

  assign raddr[0] = base0 + AW'(c0);
  assign raddr[1] = base0 + AW'(c1);
  assign raddr[2] = base1 + AW'(c0);
  assign raddr[3] = base1 + AW'(c1);

  assign we    = s2_valid && !s2_query && (32'(s2_idx) < 32'(DEPTH));
  assign waddr = AW'(s2_idx);

  for (genvar g = 0; g < 4; g++) begin : g_bank
    tthq_ram #(
      .WIDTH (HB),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (s2_height),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  // stage 3: corner heights arrive, pick triangle
  logic          s3_valid;
  logic [3:0]    s3_in;
  logic [FB-1:0] s3_dx;
  logic [FB-1:0] s3_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid & s2_query;
    end
  end

  always_ff @(posedge clk) begin
    s3_in <= in_grid;
    s3_dx <= s2_u[FB-1:0];
    s3_dz <= s2_w[FB-1:0];
  end

  logic signed [HB-1:0] ha;
  logic signed [HB-1:0] hb;
  logic signed [HB-1:0] hc;
  logic signed [HB-1:0] hd;
  logic                 upper;
  logic [FB:0]          one;

  assign ha    = s3_in[0] ? $signed(rdata[0]) : '0;
  assign hb    = s3_in[1] ? $signed(rdata[1]) : '0;
  assign hc    = s3_in[2] ? $signed(rdata[2]) : '0;
  assign hd    = s3_in[3] ? $signed(rdata[3]) : '0;
  assign one   = (FB + 1)'(1) << FB;
  assign upper = (({1'b0, s3_dx} + {1'b0, s3_dz}) < one);

  logic                 s4_valid;
  logic signed [HB-1:0] s4_base;
  logic signed [HB:0]   s4_e1;
  logic signed [HB:0]   s4_e2;
  logic [FB:0]          s4_f1;
  logic [FB:0]          s4_f2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upper) begin
      s4_base <= ha;
      s4_e1   <= (HB + 1)'(hb) - (HB + 1)'(ha);
      s4_e2   <= (HB + 1)'(hc) - (HB + 1)'(ha);
      s4_f1   <= {1'b0, s3_dx};
      s4_f2   <= {1'b0, s3_dz};
    end else begin
      s4_base <= hd;
      s4_e1   <= (HB + 1)'(hc) - (HB + 1)'(hd);
      s4_e2   <= (HB + 1)'(hb) - (HB + 1)'(hd);
      s4_f1   <= one - {1'b0, s3_dx};
      s4_f2   <= one - {1'b0, s3_dz};
    end
  end

  // stage 5: products
  localparam int PW = HB + FB + 3;

  logic                 s5_valid;
  logic signed [HB-1:0] s5_base;
  logic signed [PW-1:0] s5_p1;
  logic signed [PW-1:0] s5_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  // full-width signed products: the register width sets the operand width
  always_ff @(posedge clk) begin
    s5_base <= s4_base;
    s5_p1   <= s4_e1 * $signed({1'b0, s4_f1});
    s5_p2   <= s4_e2 * $signed({1'b0, s4_f2});
  end

  // sum, round half up, saturate
  localparam int AccW = PW + 2;

  logic signed [AccW-1:0]    acc;
  logic signed [AccW-FB-1:0] hq;
  logic signed [HB-1:0]      hsat;

  assign acc = ($signed(AccW'(s5_base)) <<< FB) + AccW'(s5_p1) + AccW'(s5_p2)
             + $signed(AccW'(1) << (FB - 1));
  assign hq  = acc[AccW-1:FB];

  always_comb begin
    if (hq > $signed((AccW - FB)'({1'b0, {(HB - 1){1'b1}}}))) begin
      hsat = {1'b0, {(HB - 1){1'b1}}};
    end else if (hq < -$signed((AccW - FB)'({1'b1, {(HB - 1){1'b0}}}))) begin
      hsat = {1'b1, {(HB - 1){1'b0}}};
    end else begin
      hsat = hq[HB-1:0];
    end
  end

  logic [HB-1:0] fifo_q;

  tthq_out_fifo #(
    .WIDTH (HB),
    .DEPTH (FD)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s5_valid),
    .push_data (hsat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (fifo_q)
  );

  assign height_out = $signed(fifo_q);

endmodule

@@ rtl/tthq_ram.sv @@
// Generic single write, single read synchronous RAM with registered read.
// No dependencies.
module tthq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4225
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tthq_out_fifo.sv @@
// Result item queue between the arithmetic pipeline and the output channel.
// Depends on nothing; the producer never pushes when full.
module tthq_out_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

@@ tb/tb_terrain_triangle_height_query.sv @@
// Testbench for terrain_triangle_height_query: fills the low part of the vertex
// height store, then runs directed and random queries checked against a predictor.
// Depends on rtl/tthq_pkg.sv and rtl/terrain_triangle_height_query.sv.
`timescale 1ns / 1ps

module tb_terrain_triangle_height_query;

  localparam int STORE_DEPTH = 65 * 65;
  // random grids stay within this many cells so every corner they reach is loaded
  localparam int FILL_CELLS  = 16;
  localparam int FILL_DEPTH  = (FILL_CELLS + 1) * (FILL_CELLS + 1);
  localparam int STALL_LIMIT = 5000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [12:0]        vertex_index;
  logic signed [23:0] vertex_height;
  logic signed [31:0] world_x;
  logic signed [31:0] world_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] height_out;

  terrain_triangle_height_query dut (.*);

  // predictor state
  logic signed [23:0] height_store [STORE_DEPTH];
  logic [6:0]         across_reg;
  logic [6:0]         down_reg;
  logic [31:0]        inv_cell_reg;
  logic signed [23:0] expected_heights [$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int queries_sent;
  int loads_sent;
  int results_checked;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(v * inv / 2^16), v up to 2^31 in magnitude
  function automatic longint scale_coord(longint v, logic [31:0] inv);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (v < 0) ? 64'(-v) : 64'(v);
    prod = mag * {32'd0, inv};
    if (v < 0) return -longint'((prod + 64'hFFFF) >> 16);
    return longint'(prod >> 16);
  endfunction

  function automatic longint corner_height(longint row, longint col, longint ncols,
                                           longint nrows);
    if (row < 0 || col < 0 || row > nrows || col > ncols) return 0;
    return longint'(height_store[row * (ncols + 1) + col]);
  endfunction

  function automatic logic signed [23:0] interp_height(logic signed [31:0] x,
                                                       logic signed [31:0] z);
    longint ncols, nrows, u, w, col, row, dx, dz, a, b, c, d, acc, h;
    ncols = (across_reg > 64) ? 64 : longint'(across_reg);
    nrows = (down_reg > 64) ? 64 : longint'(down_reg);
    u = scale_coord(longint'(x), inv_cell_reg) + (ncols << 15);
    w = scale_coord(-longint'(z), inv_cell_reg) + (nrows << 15);
    col = u >>> 16;
    row = w >>> 16;
    dx = u & 64'hFFFF;
    dz = w & 64'hFFFF;
    a = corner_height(row, col, ncols, nrows);
    b = corner_height(row, col + 1, ncols, nrows);
    c = corner_height(row + 1, col, ncols, nrows);
    d = corner_height(row + 1, col + 1, ncols, nrows);
    if (dx + dz < 65536) acc = a * 65536 + (b - a) * dx + (c - a) * dz;
    else acc = d * 65536 + (c - d) * (65536 - dx) + (b - d) * (65536 - dz);
    h = (acc + 32768) >>> 16;
    if (h > 8388607) h = 8388607;
    if (h < -8388608) h = -8388608;
    return h[23:0];
  endfunction

  // drive one item; valid stays high afterwards unless the next call idles
  task automatic send_item(tthq_pkg::action_t act, logic [12:0] idx,
                           logic signed [23:0] h, logic signed [31:0] x,
                           logic signed [31:0] z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    action        = act;
    vertex_index  = idx;
    vertex_height = h;
    world_x       = x;
    world_z       = z;
    do @(posedge clk); while (!in_ready);
    if (act == tthq_pkg::ACT_LOAD) begin
      loads_sent++;
      if (idx < STORE_DEPTH) height_store[idx] = h;
    end else begin
      queries_sent++;
      expected_heights = {expected_heights, interp_height(x, z)};
    end
  endtask

  task automatic end_items();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // loads give no result, so allow the pipeline depth after the queue drains
  task automatic drain();
    end_items();
    wait (expected_heights.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(tthq_pkg::cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      tthq_pkg::CFG_CELLS_ACROSS: across_reg = value[6:0];
      tthq_pkg::CFG_CELLS_DOWN:   down_reg = value[6:0];
      tthq_pkg::CFG_INV_CELL:     inv_cell_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [6:0] across, logic [6:0] down, logic [31:0] inv);
    drain();
    write_reg(tthq_pkg::CFG_CELLS_ACROSS, {25'd0, across});
    write_reg(tthq_pkg::CFG_CELLS_DOWN, {25'd0, down});
    write_reg(tthq_pkg::CFG_INV_CELL, inv);
  endtask

  // load the four corners of one cell of a grid with the given column count
  task automatic load_cell(int row, int col, int ncols);
    int base;
    base = row * (ncols + 1) + col;
    send_item(tthq_pkg::ACT_LOAD, 13'(base), 24'($urandom), 32'd0, 32'd0);
    send_item(tthq_pkg::ACT_LOAD, 13'(base + 1), 24'($urandom), 32'd0, 32'd0);
    send_item(tthq_pkg::ACT_LOAD, 13'(base + ncols + 1), 24'($urandom), 32'd0, 32'd0);
    send_item(tthq_pkg::ACT_LOAD, 13'(base + ncols + 2), 24'($urandom), 32'd0, 32'd0);
  endtask

  // position mostly inside or just around the grid, sometimes anywhere
  function automatic logic signed [31:0] pick_coord(logic [6:0] cells);
    longint cell_len, span;
    if ($urandom_range(9) == 0) return $urandom;
    cell_len = (inv_cell_reg == 0) ? 1000 : (64'd1 << 32) / inv_cell_reg;
    span = (longint'(cells > 64 ? 64 : cells) / 2 + 2) * cell_len;
    if (span > 32'h7FFF_FFFF) span = 32'h7FFF_FFFF;
    if (span < 1) span = 1;
    return 32'(longint'($urandom_range(32'(2 * span))) - span);
  endfunction

  task automatic test_fill_store();
    for (int i = 0; i < FILL_DEPTH; i++)
      send_item(tthq_pkg::ACT_LOAD, 13'(i), 24'($urandom), 32'd0, 32'd0);
  endtask

  task automatic test_directed();
    // cells touched by the directed queries on the full-size grid
    load_cell(63, 63, 64);
    load_cell(31, 32, 64);
    load_cell(32, 32, 64);
    load_cell(31, 33, 64);
    // extreme heights at the first and last vertex, loads past the store end
    send_item(tthq_pkg::ACT_LOAD, 13'd0, 24'sh7FFFFF, 32'd0, 32'd0);
    send_item(tthq_pkg::ACT_LOAD, 13'd4224, 24'sh800000, 32'd0, 32'd0);
    send_item(tthq_pkg::ACT_LOAD, 13'd4225, 24'sh123456, 32'd0, 32'd0);
    send_item(tthq_pkg::ACT_LOAD, 13'h1FFF, -24'sd1, 32'd0, 32'd0);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'sd0, 32'sd0);
    send_item(tthq_pkg::ACT_QUERY, 13'h1FFF, 24'shFFFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'h8000_0000, 32'h8000_0000);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'h8000_0000, 32'h7FFF_FFFF);
    // corners and a near-centre point of the default grid (cell edge 12800 in Q24.8)
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, -32'sd409600, 32'sd409600);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'sd409600, -32'sd409600);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'sd6400, 32'sd6400);
    // tiny, zero and oversized grids, zero and full-scale scaling
    set_grid(7'd1, 7'd1, 32'hFFFF_FFFF);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'sd1, -32'sd1);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'sd100, 32'sd50);
    set_grid(7'd0, 7'd0, 32'd0);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'sd0, 32'sd0);
    set_grid(7'd127, 7'd127, 32'd1 << 24);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, 32'sd256, 32'sd256);
    send_item(tthq_pkg::ACT_QUERY, 13'd0, 24'sd0, -32'sd8192, 32'sd8192);
    set_grid(7'd64, 7'd64, 32'd335544);
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    drain();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        // new grid each block of items; cells in 1..16 so all corners are loaded
        set_grid(7'($urandom_range(FILL_CELLS - 1) + 1),
                 7'($urandom_range(FILL_CELLS - 1) + 1),
                 ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(4000000, 60000)));
      end
      if ($urandom_range(99) < 15)
        send_item(tthq_pkg::ACT_LOAD, ($urandom_range(7) == 0) ? 13'($urandom) :
                  13'($urandom_range(STORE_DEPTH - 1)), 24'($urandom), $urandom, $urandom);
      else
        send_item(tthq_pkg::ACT_QUERY, 13'($urandom), 24'($urandom),
                  pick_coord(across_reg), pick_coord(down_reg));
    end
  endtask

  // receiver and result check
  always @(negedge clk) out_ready = (rst) ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_heights.size() == 0) begin
        $display("%0t: unexpected result height_out=%0d", $time, height_out);
        fail_count++;
      end else begin
        if (height_out !== expected_heights[0]) begin
          $display("%0t: height_out mismatch expected=%0d actual=%0d", $time,
                   expected_heights[0], height_out);
          fail_count++;
        end
        void'(expected_heights.pop_front());
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_index = tthq_pkg::CFG_CELLS_ACROSS; cfg_data = 32'd0;
    in_valid = 1'b0; action = tthq_pkg::ACT_LOAD; vertex_index = 13'd0;
    vertex_height = 24'sd0;
    world_x = 32'sd0; world_z = 32'sd0; out_ready = 1'b0;
    fail_count = 0; queries_sent = 0; loads_sent = 0; results_checked = 0;
    quiet_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    across_reg = tthq_pkg::CELLS_ACROSS_RESET; down_reg = tthq_pkg::CELLS_DOWN_RESET;
    inv_cell_reg = tthq_pkg::INV_CELL_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_fill_store();
    test_directed();
    test_random(100, 17, 58);
    test_random(100, 58, 17);
    test_random(100, 0, 0);
    drain();
    $display("Covered %0d loads and %0d queries over several grid settings;", loads_sent,
             queries_sent);
    $display("%0d results checked, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
